// ===== rtl/core/msm_pkg.sv =====
// shared types and constants for the merge sort with median block
`timescale 1ns / 1ps
package msm_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 24;

	// bank codes of the two value stores
	localparam logic BANK_A = 1'b0;
	localparam logic BANK_B = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_FETCH,
		ST_MERGE,
		ST_MED_RD,
		ST_MED,
		ST_EMIT_RD,
		ST_EMIT
	} msm_state_t;

	// control from the sequencer to the bank store
	typedef struct packed {
		logic wr_en;
		logic wr_bank;
		logic rd_bank;
	} msm_mem_ctl_t;

endpackage

// ===== rtl/core/msm_in_if.sv =====
// input channel: one time value per beat with a last marker
`timescale 1ns / 1ps
interface msm_in_if import msm_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] time_value;
	logic                  last;

	modport source (output valid, output time_value, output last, input ready);
	modport sink (input valid, input time_value, input last, output ready);
endinterface

// ===== rtl/core/msm_out_if.sv =====
// output channel: one sorted value per beat with median and flags
`timescale 1ns / 1ps
interface msm_out_if import msm_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] sorted_value;
	logic [VALUE_BITS:0]   median_half_units;
	logic                  overflowed;
	logic                  last_out;

	modport source (output valid, output sorted_value, output median_half_units,
		output overflowed, output last_out, input ready);
	modport sink (input valid, input sorted_value, input median_half_units,
		input overflowed, input last_out, output ready);
endinterface

// ===== rtl/core/msm_store.sv =====
// two value banks, one write port and two registered read ports each
`timescale 1ns / 1ps
module msm_store import msm_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  msm_mem_ctl_t          ctl,
	input  logic [AW-1:0]         wr_addr,
	input  logic [VALUE_BITS-1:0] wr_data,
	input  logic [AW-1:0]         rd_addr_a,
	input  logic [AW-1:0]         rd_addr_b,
	output logic [VALUE_BITS-1:0] rd_data_a,
	output logic [VALUE_BITS-1:0] rd_data_b
);

	logic [VALUE_BITS-1:0] bank_a_mem [DEPTH];
	logic [VALUE_BITS-1:0] bank_b_mem [DEPTH];
	logic [VALUE_BITS-1:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;
	logic                  rd_bank_q;

	// bank a
	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_bank == BANK_A) begin
			bank_a_mem[wr_addr] <= wr_data;
		end
		a_rd0_q <= bank_a_mem[rd_addr_a];
		a_rd1_q <= bank_a_mem[rd_addr_b];
	end

	// bank b
	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_bank == BANK_B) begin
			bank_b_mem[wr_addr] <= wr_data;
		end
		b_rd0_q <= bank_b_mem[rd_addr_a];
		b_rd1_q <= bank_b_mem[rd_addr_b];
	end

	// bank select follows the read data
	always_ff @(posedge clk) begin
		rd_bank_q <= ctl.rd_bank;
	end

	assign rd_data_a = (rd_bank_q == BANK_B) ? b_rd0_q : a_rd0_q;
	assign rd_data_b = (rd_bank_q == BANK_B) ? b_rd1_q : a_rd1_q;

endmodule

// ===== rtl/core/msm_seq.sv =====
// sequencer: load, bottom-up merge passes with a shared comparator, median, emit
`timescale 1ns / 1ps
module msm_seq import msm_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1),
	localparam int SW        = $clog2(DEPTH) + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	msm_in_if.sink                values,
	msm_out_if.source             sorted,
	output msm_mem_ctl_t          mem_ctl,
	output logic [AW-1:0]         wr_addr,
	output logic [VALUE_BITS-1:0] wr_data,
	output logic [AW-1:0]         rd_addr_a,
	output logic [AW-1:0]         rd_addr_b,
	input  logic [VALUE_BITS-1:0] rd_data_a,
	input  logic [VALUE_BITS-1:0] rd_data_b
);

	msm_state_t          state_q, state_d;
	logic [CW-1:0]       count_q;
	logic                ovf_q;
	logic                src_q;
	logic [SW-1:0]       width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic [CW-1:0]       idx_q;
	logic [VALUE_BITS:0] med_q;

	logic                in_acc, out_acc, full;
	logic [CW-1:0]       count_new;
	logic [SW-1:0]       n_w, lo_w, lo_2w, mid_c, hi_c, half_w;
	logic                a_ok, b_ok, take_a, run_end, pass_end, sort_end, emit_last;

	assign in_acc  = values.valid && values.ready;
	assign out_acc = sorted.valid && sorted.ready;
	assign full    = (count_q == CW'(DEPTH));
	assign count_new = full ? count_q : count_q + CW'(1);

	// run bounds and merge decisions
	assign n_w      = SW'(count_q);
	assign lo_w     = lo_q + width_q;
	assign lo_2w    = lo_q + (width_q << 1);
	assign mid_c    = (lo_w > n_w) ? n_w : lo_w;
	assign hi_c     = (lo_2w > n_w) ? n_w : lo_2w;
	assign a_ok     = a_q < mid_q;
	assign b_ok     = b_q < hi_q;
	assign take_a   = a_ok && (!b_ok || rd_data_a <= rd_data_b);
	assign run_end  = (k_q + SW'(1) == hi_q);
	assign pass_end = run_end && (hi_q == n_w);
	assign sort_end = pass_end && ((width_q << 1) >= n_w);
	assign half_w   = n_w >> 1;
	assign emit_last = (idx_q + CW'(1) == count_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshakes and store control
	always_comb begin
		state_d       = state_q;
		values.ready  = 1'b0;
		sorted.valid  = 1'b0;
		mem_ctl       = '{wr_en: 1'b0, wr_bank: BANK_A, rd_bank: src_q};
		wr_addr       = count_q[AW-1:0];
		wr_data       = values.time_value;
		rd_addr_a     = idx_q[AW-1:0];
		rd_addr_b     = idx_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				values.ready   = 1'b1;
				mem_ctl.wr_en  = values.valid && !full;
				if (values.valid && values.last) begin
					state_d = (count_new == CW'(1)) ? ST_MED_RD : ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				rd_addr_a = a_q[AW-1:0];
				rd_addr_b = b_q[AW-1:0];
				state_d   = ST_MERGE;
			end
			ST_MERGE: begin
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_bank = ~src_q;
				wr_addr         = k_q[AW-1:0];
				wr_data         = take_a ? rd_data_a : rd_data_b;
				if (sort_end) begin
					state_d = ST_MED_RD;
				end else if (run_end) begin
					state_d = ST_SETUP;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_MED_RD: begin
				// odd count reads the middle twice, so the sum is always twice the median
				rd_addr_a = count_q[0] ? half_w[AW-1:0] : half_w[AW-1:0] - AW'(1);
				rd_addr_b = half_w[AW-1:0];
				state_d   = ST_MED;
			end
			ST_MED: begin
				state_d = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				sorted.valid = 1'b1;
				if (sorted.ready) begin
					state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			src_q   <= BANK_A;
		end else if (in_acc) begin
			count_q <= count_new;
			if (full) begin
				ovf_q <= 1'b1;
			end
			src_q <= BANK_A;
		end else if (state_q == ST_MERGE && pass_end) begin
			src_q <= ~src_q;
		end else if (out_acc && emit_last) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	// run pointers of the merge passes
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				width_q <= SW'(1);
				lo_q    <= '0;
			end
			ST_SETUP: begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				a_q   <= lo_q;
				b_q   <= mid_c;
				k_q   <= lo_q;
			end
			ST_MERGE: begin
				if (take_a) begin
					a_q <= a_q + SW'(1);
				end else begin
					b_q <= b_q + SW'(1);
				end
				k_q <= k_q + SW'(1);
				if (pass_end) begin
					width_q <= width_q << 1;
					lo_q    <= '0;
				end else if (run_end) begin
					lo_q <= hi_q;
				end
			end
			default: begin
			end
		endcase
	end

	// median and emit index
	always_ff @(posedge clk) begin
		if (state_q == ST_MED) begin
			med_q <= {1'b0, rd_data_a} + {1'b0, rd_data_b};
			idx_q <= '0;
		end else if (out_acc) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	assign sorted.sorted_value      = rd_data_a;
	assign sorted.median_half_units = med_q;
	assign sorted.overflowed        = ovf_q;
	assign sorted.last_out          = emit_last;

	// the block never takes input while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(values.ready && sorted.valid))
		else $error("input taken while emitting");

	// merge pointers stay inside their runs and account for every written entry
	a_merge_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (a_q <= mid_q && b_q <= hi_q && k_q < hi_q
			&& (a_q - lo_q) + (b_q - mid_q) == (k_q - lo_q)))
		else $error("merge pointers out of step");

	// stored count never exceeds the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stored count beyond depth");

	// the final beat of a set clears it and reopens loading
	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && sorted.last_out) |=> (state_q == ST_LOAD && count_q == '0 && !ovf_q))
		else $error("set not cleared after final beat");

	// emit index stays below the count
	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q < count_q))
		else $error("emit index past count");

endmodule

// ===== rtl/core/merge_sort_with_median_top.sv =====
// top level of the merge sort with median block
`timescale 1ns / 1ps
// Collects a set of unsigned time values on the values channel, one per beat;
// the beat with last high closes the set. Up to DEPTH values are kept, later
// ones are dropped and every result of that set reports overflowed.
// After the closing beat the kept values are sorted ascending with a stable
// bottom-up merge sort between two banks, one comparison and one write for
// each fetch and merge state pair through a single shared comparator, then
// streamed on the sorted channel, one value per beat, each with the median
// times two and last_out on the final value.
// A set of n kept values is loaded, then merged in ceil(log2 n) passes
// with a setup state opening each run and a fetch and a merge state for
// each output entry; the median is then read, and each emitted beat is
// read from the banks before it is offered.
// values.ready is high only while loading; no input is taken from the
// closing beat until the last result beat is accepted.
// A stalled receiver holds the current beat stable; the next value is not
// read until it is taken. Reset clears the count, the overflow flag and the
// sequencer; bank contents are left as they are.
module merge_sort_with_median_top import msm_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic      clk,
	input  logic      arst_n,
	msm_in_if.sink    values,
	msm_out_if.source sorted
);

	msm_mem_ctl_t          mem_ctl;
	logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
	logic [VALUE_BITS-1:0] wr_data, rd_data_a, rd_data_b;

	// sequencer with the shared comparator
	msm_seq #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.values    (values),
		.sorted    (sorted),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// ping-pong value banks
	msm_store #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk       (clk),
		.ctl       (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

endmodule
